// ===== rtl/core/stmm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse triple multiply package
// Opcodes, register indexes, controller states and the command and status
// bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package stmm_pkg;

  localparam int DIM_W   = 13;
  localparam int IDX_W   = 12;
  localparam int VAL_W   = 32;
  localparam int ACC_W   = 64;
  localparam int COUNT_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] OP_COMPUTE    = 2'd2;
  localparam logic [1:0] OP_IGNORED    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COLS = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PAIR,
    S_PROBE,
    S_CMP,
    S_CNT,
    S_CNT_CHK,
    S_EMIT_RD,
    S_EMIT_CHK,
    S_EMPTY,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_left;
    logic load_right;
    logic start;
    logic pair_adv;
    logic mul;
    logic k_clr;
    logic rd;
    logic k_inc;
    logic merge;
    logic append;
    logic kept_inc;
    logic emit;
    logic emit_empty;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic dims_ok;
    logic pair_hit;
    logic pair_last;
    logic k_at_cnt;
    logic key_hit;
    logic val_nz;
    logic kept_zero;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [ACC_W-1:0] val;
  } prod_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/stmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sparse triple multiply controller
// Sequences loads, the pair walk with product store probing, the survivor
// count pass and the emit pass.
// ----------------------------------------------------------------------------
`default_nettype none

module stmm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [1:0]     in_opcode,
  output logic                in_ready,
  input  wire stmm_pkg::sts_t sts,
  output stmm_pkg::cmd_t      cmd
);
  import stmm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_opcode)
            OP_LOAD_LEFT:  cmd.load_left = 1'b1;
            OP_LOAD_RIGHT: cmd.load_right = 1'b1;
            OP_COMPUTE: begin
              cmd.start = 1'b1;
              state_nxt = sts.dims_ok ? S_PAIR : S_CNT;
            end
            default: ;
          endcase
        end
      end
      S_PAIR: begin
        if (sts.pair_hit) begin
          cmd.mul   = 1'b1;
          cmd.k_clr = 1'b1;
          state_nxt = S_PROBE;
        end else begin
          cmd.pair_adv = 1'b1;
          if (sts.pair_last) begin
            cmd.k_clr = 1'b1;
            state_nxt = S_CNT;
          end
        end
      end
      S_PROBE: begin
        if (sts.k_at_cnt) begin
          cmd.append   = 1'b1;
          cmd.pair_adv = 1'b1;
          state_nxt    = sts.pair_last ? S_CNT : S_PAIR;
          cmd.k_clr    = sts.pair_last;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.key_hit) begin
          cmd.merge    = 1'b1;
          cmd.pair_adv = 1'b1;
          state_nxt    = sts.pair_last ? S_CNT : S_PAIR;
          cmd.k_clr    = sts.pair_last;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_CNT: begin
        if (sts.k_at_cnt) begin
          cmd.k_clr = 1'b1;
          state_nxt = sts.kept_zero ? S_EMPTY : S_EMIT_RD;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_CNT_CHK;
        end
      end
      S_CNT_CHK: begin
        cmd.kept_inc = sts.val_nz;
        cmd.k_inc    = 1'b1;
        state_nxt    = S_CNT;
      end
      S_EMIT_RD: begin
        if (sts.k_at_cnt) begin
          state_nxt = S_DONE;
        end else if (!sts.out_busy) begin
          cmd.rd    = 1'b1;
          state_nxt = S_EMIT_CHK;
        end
      end
      S_EMIT_CHK: begin
        cmd.emit  = sts.val_nz;
        cmd.k_inc = 1'b1;
        state_nxt = S_EMIT_RD;
      end
      S_EMPTY: begin
        if (!sts.out_busy) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/stmm_dp.sv =====
// ----------------------------------------------------------------------------
// Sparse triple multiply datapath
// Triple stores, configuration registers, the multiplier, the product store
// memory with its scan counters, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stmm_dp #(
  parameter int MAX_LEFT_TERMS    = 8,
  parameter int MAX_RIGHT_TERMS   = 8,
  parameter int MAX_PRODUCT_TERMS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire stmm_pkg::cmd_t                      cmd,
  output stmm_pkg::sts_t                           sts,
  input  wire logic [stmm_pkg::IDX_W-1:0]          in_entry_row,
  input  wire logic [stmm_pkg::IDX_W-1:0]          in_entry_col,
  input  wire logic signed [stmm_pkg::VAL_W-1:0]   in_entry_value,
  input  wire logic                                cfg_we,
  input  wire logic [stmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [stmm_pkg::DIM_W-1:0]          cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [stmm_pkg::DIM_W-1:0]               out_product_rows,
  output logic [stmm_pkg::DIM_W-1:0]               out_product_cols,
  output logic [stmm_pkg::COUNT_W-1:0]             out_entry_count,
  output logic                                     out_entry_valid,
  output logic [stmm_pkg::IDX_W-1:0]               out_result_row,
  output logic [stmm_pkg::IDX_W-1:0]               out_result_col,
  output logic signed [stmm_pkg::ACC_W-1:0]        out_result_value,
  output logic                                     out_last,
  output logic                                     out_overflow
);
  import stmm_pkg::*;

  localparam int LAW = (MAX_LEFT_TERMS > 1) ? $clog2(MAX_LEFT_TERMS) : 1;
  localparam int LCW = $clog2(MAX_LEFT_TERMS + 1);
  localparam int RAW = (MAX_RIGHT_TERMS > 1) ? $clog2(MAX_RIGHT_TERMS) : 1;
  localparam int RCW = $clog2(MAX_RIGHT_TERMS + 1);
  localparam int PAW = (MAX_PRODUCT_TERMS > 1) ? $clog2(MAX_PRODUCT_TERMS) : 1;
  localparam int PCW = $clog2(MAX_PRODUCT_TERMS + 1);

  logic [DIM_W-1:0] left_rows_r, left_cols_r, right_rows_r, right_cols_r;

  logic [IDX_W-1:0]        left_row_r  [MAX_LEFT_TERMS];
  logic [IDX_W-1:0]        left_col_r  [MAX_LEFT_TERMS];
  logic signed [VAL_W-1:0] left_val_r  [MAX_LEFT_TERMS];
  logic [IDX_W-1:0]        right_row_r [MAX_RIGHT_TERMS];
  logic [IDX_W-1:0]        right_col_r [MAX_RIGHT_TERMS];
  logic signed [VAL_W-1:0] right_val_r [MAX_RIGHT_TERMS];

  logic [LCW-1:0] left_cnt_r;
  logic [RCW-1:0] right_cnt_r;
  logic           ovf_flag_r;
  logic           ovf_r;

  logic [LAW-1:0] i_r;
  logic [RAW-1:0] j_r;
  logic [PCW-1:0] cnt_r, k_r, kept_r, emitted_r;

  logic signed [ACC_W-1:0] prod_r;
  logic [IDX_W-1:0]        key_row_r, key_col_r;

  prod_entry_t prod_mem [MAX_PRODUCT_TERMS];
  prod_entry_t rd_q_r;

  logic            mem_we;
  logic [PAW-1:0]  mem_wa;
  prod_entry_t     mem_wd;
  logic            pair_i_last, pair_j_last;
  logic            left_full, right_full, prod_full;

  assign left_full   = (left_cnt_r == LCW'(MAX_LEFT_TERMS));
  assign right_full  = (right_cnt_r == RCW'(MAX_RIGHT_TERMS));
  assign prod_full   = (cnt_r == PCW'(MAX_PRODUCT_TERMS));
  assign pair_i_last = (i_r == LAW'(left_cnt_r - LCW'(1)));
  assign pair_j_last = (j_r == RAW'(right_cnt_r - RCW'(1)));

  always_comb begin
    sts.dims_ok   = (left_cols_r == right_rows_r) && (left_cnt_r != '0)
                    && (right_cnt_r != '0);
    sts.pair_hit  = (left_col_r[i_r] == right_row_r[j_r]);
    sts.pair_last = pair_i_last && pair_j_last;
    sts.k_at_cnt  = (k_r == cnt_r);
    sts.key_hit   = (rd_q_r.row == key_row_r) && (rd_q_r.col == key_col_r);
    sts.val_nz    = (rd_q_r.val != '0);
    sts.kept_zero = (kept_r == '0);
    sts.out_busy  = out_valid && !out_ready;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = k_r[PAW-1:0];
    mem_wd = '{row: key_row_r, col: key_col_r, val: prod_r};
    if (cmd.merge) begin
      mem_we     = 1'b1;
      mem_wd.val = rd_q_r.val + prod_r;
    end else if (cmd.append && !prod_full) begin
      mem_we = 1'b1;
      mem_wa = cnt_r[PAW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      prod_mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd) begin
      rd_q_r <= prod_mem[k_r[PAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_left && !left_full) begin
      left_row_r[left_cnt_r[LAW-1:0]] <= in_entry_row;
      left_col_r[left_cnt_r[LAW-1:0]] <= in_entry_col;
      left_val_r[left_cnt_r[LAW-1:0]] <= in_entry_value;
    end
    if (cmd.load_right && !right_full) begin
      right_row_r[right_cnt_r[RAW-1:0]] <= in_entry_row;
      right_col_r[right_cnt_r[RAW-1:0]] <= in_entry_col;
      right_val_r[right_cnt_r[RAW-1:0]] <= in_entry_value;
    end
    if (cmd.mul) begin
      prod_r    <= left_val_r[i_r] * right_val_r[j_r];
      key_row_r <= left_row_r[i_r];
      key_col_r <= right_col_r[j_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_rows_r  <= '0;
      left_cols_r  <= '0;
      right_rows_r <= '0;
      right_cols_r <= '0;
      left_cnt_r   <= '0;
      right_cnt_r  <= '0;
      ovf_flag_r   <= 1'b0;
      ovf_r        <= 1'b0;
      i_r          <= '0;
      j_r          <= '0;
      cnt_r        <= '0;
      k_r          <= '0;
      kept_r       <= '0;
      emitted_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT_ROWS:  left_rows_r  <= cfg_data;
          REG_LEFT_COLS:  left_cols_r  <= cfg_data;
          REG_RIGHT_ROWS: right_rows_r <= cfg_data;
          REG_RIGHT_COLS: right_cols_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_left) begin
        if (left_full) ovf_flag_r <= 1'b1;
        else left_cnt_r <= left_cnt_r + LCW'(1);
      end
      if (cmd.load_right) begin
        if (right_full) ovf_flag_r <= 1'b1;
        else right_cnt_r <= right_cnt_r + RCW'(1);
      end
      if (cmd.start) begin
        ovf_r     <= ovf_flag_r;
        i_r       <= '0;
        j_r       <= '0;
        cnt_r     <= '0;
        k_r       <= '0;
        kept_r    <= '0;
        emitted_r <= '0;
      end
      if (cmd.pair_adv) begin
        if (pair_j_last) begin
          j_r <= '0;
          i_r <= i_r + LAW'(1);
        end else begin
          j_r <= j_r + RAW'(1);
        end
      end
      if (cmd.append) begin
        if (prod_full) ovf_r <= 1'b1;
        else cnt_r <= cnt_r + PCW'(1);
      end
      if (cmd.k_clr) k_r <= '0;
      else if (cmd.k_inc) k_r <= k_r + PCW'(1);
      if (cmd.kept_inc) kept_r <= kept_r + PCW'(1);
      if (cmd.emit) emitted_r <= emitted_r + PCW'(1);
      if (cmd.finish) begin
        left_cnt_r  <= '0;
        right_cnt_r <= '0;
        ovf_flag_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit || cmd.emit_empty) begin
      out_product_rows <= left_rows_r;
      out_product_cols <= right_cols_r;
      out_overflow     <= ovf_r;
    end
    if (cmd.emit) begin
      out_entry_count  <= COUNT_W'(kept_r);
      out_entry_valid  <= 1'b1;
      out_result_row   <= rd_q_r.row;
      out_result_col   <= rd_q_r.col;
      out_result_value <= rd_q_r.val;
      out_last         <= (emitted_r + PCW'(1) == kept_r);
    end else if (cmd.emit_empty) begin
      out_entry_count  <= '0;
      out_entry_valid  <= 1'b0;
      out_result_row   <= '0;
      out_result_col   <= '0;
      out_result_value <= '0;
      out_last         <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sparse_triple_matrix_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// Sparse triple matrix multiply unit
// Multiplies two sparse matrices given as coordinate triples.
// ----------------------------------------------------------------------------
// Load transfers are taken in the idle state. A compute command walks every
// pair of loaded A and B triples when the inner dimensions agree and both hold
// triples; a matching pair is multiplied, then product store entries are probed
// one at a time through the single read port of the product store, and the
// product is appended when no entry matches, before the walk moves on. After
// the walk the store is read once to count surviving entries and, unless none
// survive, once more to emit them; a result that waits for out_ready holds the
// emit pass. Input is taken only while no compute is running.
`default_nettype none

module sparse_triple_matrix_multiply_unit #(
  parameter int MAX_LEFT_TERMS    = 8,
  parameter int MAX_RIGHT_TERMS   = 8,
  parameter int MAX_PRODUCT_TERMS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          in_opcode,
  input  wire logic [stmm_pkg::IDX_W-1:0]          in_entry_row,
  input  wire logic [stmm_pkg::IDX_W-1:0]          in_entry_col,
  input  wire logic signed [stmm_pkg::VAL_W-1:0]   in_entry_value,
  input  wire logic                                cfg_we,
  input  wire logic [stmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [stmm_pkg::DIM_W-1:0]          cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [stmm_pkg::DIM_W-1:0]               out_product_rows,
  output logic [stmm_pkg::DIM_W-1:0]               out_product_cols,
  output logic [stmm_pkg::COUNT_W-1:0]             out_entry_count,
  output logic                                     out_entry_valid,
  output logic [stmm_pkg::IDX_W-1:0]               out_result_row,
  output logic [stmm_pkg::IDX_W-1:0]               out_result_col,
  output logic signed [stmm_pkg::ACC_W-1:0]        out_result_value,
  output logic                                     out_last,
  output logic                                     out_overflow
);
  import stmm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  stmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  stmm_dp #(
    .MAX_LEFT_TERMS    (MAX_LEFT_TERMS),
    .MAX_RIGHT_TERMS   (MAX_RIGHT_TERMS),
    .MAX_PRODUCT_TERMS (MAX_PRODUCT_TERMS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_entry_row     (in_entry_row),
    .in_entry_col     (in_entry_col),
    .in_entry_value   (in_entry_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_product_rows (out_product_rows),
    .out_product_cols (out_product_cols),
    .out_entry_count  (out_entry_count),
    .out_entry_valid  (out_entry_valid),
    .out_result_row   (out_result_row),
    .out_result_col   (out_result_col),
    .out_result_value (out_result_value),
    .out_last         (out_last),
    .out_overflow     (out_overflow)
  );

endmodule

`default_nettype wire

// ===== tb/sparse_triple_matrix_multiply_unit_test.sv =====
// ----------------------------------------------------------------------------
// Sparse triple matrix multiply unit testbench
// Loads A and B coordinate triples, issues compute commands and checks every
// emitted product entry against a behavioral model kept in the scoreboard.
// Both channels see random idle cycles, and the dimension registers are
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_triple_matrix_multiply_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import stmm_pkg::*;

  typedef struct packed {
    logic [DIM_W-1:0]   prows;
    logic [DIM_W-1:0]   pcols;
    logic [COUNT_W-1:0] count;
    logic               evalid;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [ACC_W-1:0]   value;
    logic               last;
    logic               ovf;
  } product_t;

  class product_scoreboard;
    logic [DIM_W-1:0] dims [4];
    logic [IDX_W-1:0] a_row [8], a_col [8], b_row [8], b_col [8];
    logic [VAL_W-1:0] a_val [8], b_val [8];
    int a_cnt, b_cnt;
    bit ovf_flag;
    product_t pending [$];
    int mismatches;

    function void clear_state();
      int i;
      for (i = 0; i < 4; i++) dims[i] = '0;
      a_cnt = 0;
      b_cnt = 0;
      ovf_flag = 0;
      mismatches = 0;
    endfunction

    function void note_input(logic [1:0] op, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                             logic [VAL_W-1:0] v);
      logic [IDX_W-1:0] pr [64], pc [64];
      logic [ACC_W-1:0] pv [64], p;
      int cnt, kept, i, j, k;
      bit merged, ovf;
      product_t e;
      if (op == OP_LOAD_LEFT) begin
        if (a_cnt < 8) begin
          a_row[a_cnt] = r; a_col[a_cnt] = c; a_val[a_cnt] = v; a_cnt++;
        end else begin
          ovf_flag = 1;
        end
        return;
      end
      if (op == OP_LOAD_RIGHT) begin
        if (b_cnt < 8) begin
          b_row[b_cnt] = r; b_col[b_cnt] = c; b_val[b_cnt] = v; b_cnt++;
        end else begin
          ovf_flag = 1;
        end
        return;
      end
      if (op != OP_COMPUTE) return;
      ovf = ovf_flag;
      cnt = 0;
      if (dims[REG_LEFT_COLS] == dims[REG_RIGHT_ROWS] && a_cnt != 0 && b_cnt != 0) begin
        for (i = 0; i < a_cnt; i++) begin
          for (j = 0; j < b_cnt; j++) begin
            if (a_col[i] == b_row[j]) begin
              p = {{32{a_val[i][31]}}, a_val[i]} * {{32{b_val[j][31]}}, b_val[j]};
              merged = 0;
              for (k = 0; k < cnt && !merged; k++) begin
                if (pr[k] == a_row[i] && pc[k] == b_col[j]) begin
                  pv[k] += p;
                  merged = 1;
                end
              end
              if (!merged) begin
                if (cnt < 64) begin
                  pr[cnt] = a_row[i]; pc[cnt] = b_col[j]; pv[cnt] = p; cnt++;
                end else begin
                  ovf = 1;
                end
              end
            end
          end
        end
      end
      kept = 0;
      for (k = 0; k < cnt; k++) begin
        if (pv[k] != 0) begin
          pr[kept] = pr[k]; pc[kept] = pc[k]; pv[kept] = pv[k]; kept++;
        end
      end
      e.prows = dims[REG_LEFT_ROWS];
      e.pcols = dims[REG_RIGHT_COLS];
      e.ovf = ovf;
      if (kept == 0) begin
        e.count = '0; e.evalid = 0; e.row = '0; e.col = '0; e.value = '0; e.last = 1;
        pending.push_back(e);
      end else begin
        for (k = 0; k < kept; k++) begin
          e.count = COUNT_W'(kept); e.evalid = 1; e.row = pr[k]; e.col = pc[k];
          e.value = pv[k];
          e.last = (k + 1 == kept);
          pending.push_back(e);
        end
      end
      a_cnt = 0;
      b_cnt = 0;
      ovf_flag = 0;
    endfunction

    function void check_result(product_t got);
      product_t exp_e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: row %0d col %0d value %0d",
                                       got.row, got.col, $signed(got.value));
        return;
      end
      exp_e = pending.pop_front();
      if (got !== exp_e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch expected rows %0d cols %0d cnt %0d v %0d r %0d c %0d val %0d l %0d o %0d",
                   exp_e.prows, exp_e.pcols, exp_e.count, exp_e.evalid, exp_e.row,
                   exp_e.col, $signed(exp_e.value), exp_e.last, exp_e.ovf);
          $display("         actual   rows %0d cols %0d cnt %0d v %0d r %0d c %0d val %0d l %0d o %0d",
                   got.prows, got.pcols, got.count, got.evalid, got.row,
                   got.col, $signed(got.value), got.last, got.ovf);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_opcode = '0;
  logic [IDX_W-1:0] in_entry_row = '0;
  logic [IDX_W-1:0] in_entry_col = '0;
  logic signed [VAL_W-1:0] in_entry_value = '0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [DIM_W-1:0] out_product_rows, out_product_cols;
  logic [COUNT_W-1:0] out_entry_count;
  logic out_entry_valid;
  logic [IDX_W-1:0] out_result_row, out_result_col;
  logic signed [ACC_W-1:0] out_result_value;
  logic out_last, out_overflow;

  product_scoreboard sb;
  int idle_pct = 34;
  int stall_count = 0;
  int compute_count = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  sparse_triple_matrix_multiply_unit u_top (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      product_t got;
      got.prows = out_product_rows; got.pcols = out_product_cols;
      got.count = out_entry_count; got.evalid = out_entry_valid;
      got.row = out_result_row; got.col = out_result_col; got.value = out_result_value;
      got.last = out_last; got.ovf = out_overflow;
      sb.check_result(got);
    end
    if (rst_n && in_valid && in_ready) sb.note_input(in_opcode, in_entry_row, in_entry_col,
                                                      in_entry_value);
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count > 20000) begin
      $display("sparse_triple_matrix_multiply_unit_test NOT OK");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                           logic [VAL_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_opcode <= op;
    in_entry_row <= r;
    in_entry_col <= c;
    in_entry_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] d);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
    sb.dims[idx] = d;
  endtask

  task automatic set_dims(logic [DIM_W-1:0] lr, logic [DIM_W-1:0] lc,
                          logic [DIM_W-1:0] rr, logic [DIM_W-1:0] rc);
    write_reg(REG_LEFT_ROWS, lr);
    write_reg(REG_LEFT_COLS, lc);
    write_reg(REG_RIGHT_ROWS, rr);
    write_reg(REG_RIGHT_COLS, rc);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(6)) - 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_compute(int nkeys);
    int na, nb, i;
    logic [IDX_W-1:0] keys [4];
    for (i = 0; i < 4; i++) keys[i] = IDX_W'($urandom);
    if ($urandom_range(9) == 0) begin
      na = $urandom_range(11); nb = $urandom_range(11);
    end else begin
      na = $urandom_range(1, 8); nb = $urandom_range(1, 8);
    end
    for (i = 0; i < na + nb; i++) begin
      if ($urandom_range(19) == 0) send_item(OP_IGNORED, IDX_W'($urandom),
                                             IDX_W'($urandom), $urandom);
      if (i < na) send_item(OP_LOAD_LEFT, keys[$urandom_range(nkeys - 1)],
                            keys[$urandom_range(nkeys - 1)], rand_value());
      else send_item(OP_LOAD_RIGHT, keys[$urandom_range(nkeys - 1)],
                     keys[$urandom_range(nkeys - 1)], rand_value());
    end
    send_item(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
  endtask

  initial begin
    int i;
    sb = new();
    sb.clear_state();
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    set_dims(13'd4096, 13'd4096, 13'd4096, 13'd4096);
    send_item(OP_COMPUTE, 0, 0, 0);
    send_item(OP_LOAD_LEFT, 12'd4095, 12'd0, 32'h8000_0000);
    send_item(OP_LOAD_LEFT, 12'd0, 12'd4095, 32'h7fff_ffff);
    send_item(OP_LOAD_RIGHT, 12'd0, 12'd4095, 32'h8000_0000);
    send_item(OP_LOAD_RIGHT, 12'd4095, 12'd0, 32'hffff_ffff);
    send_item(OP_IGNORED, 12'd4095, 12'd4095, 32'hffff_ffff);
    send_item(OP_COMPUTE, 12'd4095, 12'd4095, 32'hffff_ffff);
    send_item(OP_LOAD_LEFT, 1, 2, 3);
    send_item(OP_LOAD_LEFT, 1, 2, -3);
    send_item(OP_LOAD_RIGHT, 2, 5, 7);
    send_item(OP_COMPUTE, 0, 0, 0);
    for (i = 0; i < 9; i++) send_item(OP_LOAD_LEFT, IDX_W'(i), 0, VAL_W'(i + 1));
    for (i = 0; i < 9; i++) send_item(OP_LOAD_RIGHT, 0, IDX_W'(i), VAL_W'(i + 2));
    send_item(OP_COMPUTE, 0, 0, 0);
    drain();

    set_dims(13'd0, 13'd3, 13'd5, 13'd0);
    send_item(OP_LOAD_LEFT, 1, 1, 1);
    send_item(OP_LOAD_RIGHT, 1, 1, 1);
    send_item(OP_COMPUTE, 0, 0, 0);
    drain();

    while (compute_count < 36) begin
      if (compute_count % 12 == 0) begin
        drain();
        set_dims(DIM_W'($urandom_range(4096)), compute_count == 12 ? 13'd0 : 13'd4096,
                 compute_count == 12 ? 13'd0 : 13'd4096, DIM_W'($urandom_range(4096)));
        idle_pct = (compute_count == 24) ? 0 : 34;
      end
      random_compute($urandom_range(1, 4));
      compute_count++;
    end
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("sparse_triple_matrix_multiply_unit_test OK");
    else
      $display("sparse_triple_matrix_multiply_unit_test NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sparse_triple_matrix_multiply_unit.f =====
rtl/core/stmm_pkg.sv
rtl/core/stmm_ctrl.sv
rtl/core/stmm_dp.sv
rtl/core/sparse_triple_matrix_multiply_unit.sv
tb/sparse_triple_matrix_multiply_unit_test.sv
